>>> rtl/imubc_pkg.sv
package imubc_pkg;

    localparam int CAL_SAMPLES = 32;
    localparam int AXES        = 9;
    localparam int RAW_W       = 16;
    localparam int SUM_W       = 22;
    localparam int BIAS_SHIFT  = 5;
    localparam int SENS_W      = 24;
    localparam int PROD_W      = RAW_W + 1 + SENS_W + 1;
    localparam int OUT_W       = 48;
    localparam int CNT_W       = $clog2(CAL_SAMPLES);
    localparam int RANGE_W     = 2;
    localparam int CFG_IDX_W   = 8;

    localparam int ACC_Z       = 2;

    localparam logic [RANGE_W-1:0] ACCEL_RANGE_RST = 2'd1;
    localparam logic [RANGE_W-1:0] GYRO_RANGE_RST  = 2'd2;
    localparam logic [RANGE_W-1:0] MAG_RANGE_RST   = 2'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_RANGE = 8'd0,
        REG_GYRO_RANGE  = 8'd1,
        REG_MAG_RANGE   = 8'd2
    } cfg_reg_t;

    typedef enum logic [0:0] {
        ACT_CAL  = 1'b0,
        ACT_MEAS = 1'b1
    } action_t;

    typedef struct packed {
        action_t                  action;
        logic signed [RAW_W-1:0]  acc_x_raw;
        logic signed [RAW_W-1:0]  acc_y_raw;
        logic signed [RAW_W-1:0]  acc_z_raw;
        logic signed [RAW_W-1:0]  gyr_x_raw;
        logic signed [RAW_W-1:0]  gyr_y_raw;
        logic signed [RAW_W-1:0]  gyr_z_raw;
        logic signed [RAW_W-1:0]  mag_x_raw;
        logic signed [RAW_W-1:0]  mag_y_raw;
        logic signed [RAW_W-1:0]  mag_z_raw;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0]  acc_x_scaled;
        logic signed [OUT_W-1:0]  acc_y_scaled;
        logic signed [OUT_W-1:0]  acc_z_scaled;
        logic signed [OUT_W-1:0]  gyr_x_scaled;
        logic signed [OUT_W-1:0]  gyr_y_scaled;
        logic signed [OUT_W-1:0]  gyr_z_scaled;
        logic signed [OUT_W-1:0]  mag_x_scaled;
        logic signed [OUT_W-1:0]  mag_y_scaled;
        logic signed [OUT_W-1:0]  mag_z_scaled;
        logic                     calibrated;
    } result_t;

    // sensitivities as round(units per count * 2^24)
    function automatic logic [SENS_W-1:0] acc_sens(input logic [RANGE_W-1:0] range);
        logic [SENS_W-1:0] k;
        unique case (range)
            2'd0:    k = 24'd1023;
            2'd1:    k = 24'd2047;
            2'd2:    k = 24'd4094;
            default: k = 24'd12281;
        endcase
        return k;
    endfunction

    // the unused code falls back to 2000 dps
    function automatic logic [SENS_W-1:0] gyr_sens(input logic [RANGE_W-1:0] range);
        logic [SENS_W-1:0] k;
        unique case (range)
            2'd0:    k = 24'd146801;
            2'd1:    k = 24'd293601;
            default: k = 24'd1174405;
        endcase
        return k;
    endfunction

    function automatic logic [SENS_W-1:0] mag_sens(input logic [RANGE_W-1:0] range);
        logic [SENS_W-1:0] k;
        unique case (range)
            2'd0:    k = 24'd2348810;
            2'd1:    k = 24'd4865393;
            2'd2:    k = 24'd7214203;
            default: k = 24'd9730785;
        endcase
        return k;
    endfunction

    // counts of one g at each accel range
    function automatic logic [RAW_W-1:0] one_g(input logic [RANGE_W-1:0] range);
        logic [RAW_W-1:0] g;
        unique case (range)
            2'd0:    g = 16'd16393;
            2'd1:    g = 16'd8196;
            2'd2:    g = 16'd4098;
            default: g = 16'd1366;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/imu_bias_calibrate_and_scale_unit.sv
// Static bias calibration and scaling for a nine-axis motion sensor. Each sample transfer
// carries nine raw 16-bit readings and an action bit. Calibration samples (action 0) go into
// nine 22-bit accumulators, with one g of the current accel range added to accel z; after
// CAL_SAMPLES of them each bias becomes its sum shifted right (arithmetic) by five and cut to
// 16 bits, the accumulators clear and calibrated sets. Measurement samples (action 1) give one
// result transfer: each reading minus its bias, times the sensitivity of the selected range,
// as a 48-bit value with 24 fraction bits. Calibration samples give no result. The block takes
// one sample per clock while sample_stall is low: a sample register feeds nine independent
// subtract-multiply lanes whose products land in the result register, which is offered.
// sample_stall rises only while a measurement in the sample register waits behind a result
// that is itself stalled. Range registers are written through the cfg port (index 0 accel,
// 1 gyro, 2 mag; other indexes are ignored); the user must write them only while no sample
// is in flight, which the block itself does not enforce. cfg_ready is always high.
module imu_bias_calibrate_and_scale_unit
    import imubc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,

    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [RANGE_W-1:0]    cfg_data
);

    logic [RANGE_W-1:0]      accel_range_reg;
    logic [RANGE_W-1:0]      gyro_range_reg;
    logic [RANGE_W-1:0]      mag_range_reg;

    sample_t                 s1_reg;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;

    logic [SUM_W-1:0]        sum_reg  [AXES];
    logic [SUM_W-1:0]        sum_next [AXES];
    logic [RAW_W-1:0]        bias_reg  [AXES];
    logic [RAW_W-1:0]        bias_next [AXES];
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    done_reg;
    logic                    done_next;

    result_t                 result_reg;
    result_t                 result_next;
    logic                    result_valid_reg;
    logic                    result_valid_next;

    logic                    sample_xfer;
    logic                    out_free;
    logic                    s1_is_cal;
    logic                    s1_advance;
    logic                    cal_fire;
    logic                    run_end;
    logic                    meas_load;

    logic [RAW_W-1:0]        raw [AXES];
    logic signed [PROD_W-1:0] prod [AXES];

    // ---------------------------------------------------------------- handshake
    assign out_free     = !result_valid_reg || !result_stall;
    assign s1_is_cal    = (s1_reg.action == ACT_CAL);
    assign s1_advance   = s1_valid_reg && (s1_is_cal || out_free);
    assign sample_stall = s1_valid_reg && !s1_advance;
    assign sample_xfer  = sample_valid && !sample_stall;
    assign cal_fire     = s1_valid_reg && s1_is_cal;
    assign meas_load    = s1_advance && !s1_is_cal;
    assign run_end      = cal_fire && (cnt_reg == CNT_W'(CAL_SAMPLES - 1));

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        if (sample_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (meas_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    // ---------------------------------------------------------------- lanes
    always_comb
    begin
        raw[0] = s1_reg.acc_x_raw;
        raw[1] = s1_reg.acc_y_raw;
        raw[2] = s1_reg.acc_z_raw;
        raw[3] = s1_reg.gyr_x_raw;
        raw[4] = s1_reg.gyr_y_raw;
        raw[5] = s1_reg.gyr_z_raw;
        raw[6] = s1_reg.mag_x_raw;
        raw[7] = s1_reg.mag_y_raw;
        raw[8] = s1_reg.mag_z_raw;
    end

    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        logic [SENS_W-1:0]        sens;
        logic signed [RAW_W:0]    diff;

        if (i < 3)
        begin : g_acc
            assign sens = acc_sens(accel_range_reg);
        end
        else if (i < 6)
        begin : g_gyr
            assign sens = gyr_sens(gyro_range_reg);
        end
        else
        begin : g_mag
            assign sens = mag_sens(mag_range_reg);
        end

        assign diff    = $signed({raw[i][RAW_W-1], raw[i]})
                       - $signed({bias_reg[i][RAW_W-1], bias_reg[i]});
        assign prod[i] = diff * $signed({1'b0, sens});
    end

    always_comb
    begin
        result_next              = result_reg;
        if (meas_load)
        begin
            result_next.acc_x_scaled = OUT_W'(prod[0]);
            result_next.acc_y_scaled = OUT_W'(prod[1]);
            result_next.acc_z_scaled = OUT_W'(prod[2]);
            result_next.gyr_x_scaled = OUT_W'(prod[3]);
            result_next.gyr_y_scaled = OUT_W'(prod[4]);
            result_next.gyr_z_scaled = OUT_W'(prod[5]);
            result_next.mag_x_scaled = OUT_W'(prod[6]);
            result_next.mag_y_scaled = OUT_W'(prod[7]);
            result_next.mag_z_scaled = OUT_W'(prod[8]);
            result_next.calibrated   = done_reg;
        end
    end

    // ---------------------------------------------------------------- calibration
    always_comb
    begin
        logic [RAW_W-1:0] v;
        logic [SUM_W-1:0] acc;

        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (cal_fire)
        begin
            cnt_next = run_end ? '0 : cnt_reg + CNT_W'(1);
        end
        if (run_end)
        begin
            done_next = 1'b1;
        end

        for (int i = 0; i < AXES; i++)
        begin
            v = raw[i];
            if (i == ACC_Z)
            begin
                // gravity offset so a level part calibrates to zero
                v = raw[i] + one_g(accel_range_reg);
            end
            acc          = sum_reg[i] + {{(SUM_W - RAW_W){v[RAW_W-1]}}, v};
            sum_next[i]  = sum_reg[i];
            bias_next[i] = bias_reg[i];
            if (cal_fire)
            begin
                sum_next[i] = acc;
            end
            if (run_end)
            begin
                bias_next[i] = acc[BIAS_SHIFT + RAW_W - 1:BIAS_SHIFT];
                sum_next[i]  = '0;
            end
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_range_reg  <= ACCEL_RANGE_RST;
            gyro_range_reg   <= GYRO_RANGE_RST;
            mag_range_reg    <= MAG_RANGE_RST;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            cnt_reg          <= '0;
            done_reg         <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                sum_reg[i]  <= '0;
                bias_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ACCEL_RANGE: accel_range_reg <= cfg_data;
                    REG_GYRO_RANGE:  gyro_range_reg  <= cfg_data;
                    REG_MAG_RANGE:   mag_range_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            cnt_reg          <= cnt_next;
            done_reg         <= done_next;
            for (int i = 0; i < AXES; i++)
            begin
                sum_reg[i]  <= sum_next[i];
                bias_reg[i] <= bias_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            s1_reg <= sample;
        end
        result_reg <= result_next;
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAL_SAMPLES - 1))
        else $error("sample counter past end of run");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("calibrated flag dropped");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        run_end |=> (done_reg && cnt_reg == '0 && sum_reg[0] == '0 && sum_reg[AXES-1] == '0))
        else $error("end of calibration run did not clear accumulators");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (s1_valid_reg && !s1_is_cal && result_valid_reg && result_stall))
        else $error("sample stalled without a blocked measurement");

    a_cal_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cal_fire && !result_valid_reg) |=> !result_valid_reg)
        else $error("calibration sample produced a result");
`endif

endmodule
